// ===== sv/multi_timer_expiry_table_assert.svh =====
// Assertion macros shared by the timer table RTL.
// TMR_ASSERT_IMP checks an overlapping implication and TMR_ASSERT_NXT a
// next-cycle implication, both disabled while reset is held.
`ifndef MULTI_TIMER_EXPIRY_TABLE_ASSERT_SVH
`define MULTI_TIMER_EXPIRY_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define TMR_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("timer table check failed");
`define TMR_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("timer table check failed");
`else
`define TMR_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define TMR_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

// ===== sv/tmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tmr_pkg;

    localparam int TIMER_COUNT  = 8;
    localparam int PAYLOAD_BITS = 32;

    localparam int TIME_W      = 32;
    localparam int CNT_W       = 32;
    localparam int ID_W        = 4;
    localparam int MODE_W      = 2;
    localparam int WORD_W      = 32;
    localparam int TIMER_IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int PAY_W       = (PAYLOAD_BITS < WORD_W) ? PAYLOAD_BITS : WORD_W;
    localparam int DIV_CNT_W   = $clog2(TIME_W);

    typedef logic [TIMER_IDX_W-1:0] t_tmr_idx;
    typedef logic [TIMER_COUNT-1:0] t_tmr_mask;

    typedef enum logic [MODE_W-1:0] {
        MODE_START   = 2'd0,
        MODE_CANCEL  = 2'd1,
        MODE_PROCESS = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_EXEC,
        S_DIV
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   slot_id;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] span_ms;
        logic              repeat_req;
        logic [WORD_W-1:0] event_payload;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic              fired;
        logic [ID_W-1:0]   fired_id;
        logic [WORD_W-1:0] fired_payload;
        logic [TIME_W-1:0] stamp_ms;
        logic              last;
        logic [CNT_W-1:0]  arm_total;
        logic [CNT_W-1:0]  cancel_total;
        logic [CNT_W-1:0]  expiry_total;
    } t_rsp;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== sv/tmr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tmr_req_if;
    logic          valid;
    logic          ready;
    tmr_pkg::t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/tmr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tmr_rsp_if;
    logic          valid;
    logic          ready;
    tmr_pkg::t_rsp payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/tmr_rem_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit: one quotient bit per cycle.
module tmr_rem_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tmr_pkg::TIME_W-1:0] i_dividend,
    input  logic [tmr_pkg::TIME_W-1:0] i_divisor,
    output tmr_pkg::t_div_stat        o_stat,
    output logic [tmr_pkg::TIME_W-1:0] o_rem
);
    import tmr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TIME_W-1:0]    r_dvd;
    logic [TIME_W-1:0]    r_dvs;
    logic [TIME_W-1:0]    r_rem;

    logic [TIME_W:0]      rem_sh;
    logic [TIME_W:0]      diff;
    logic [TIME_W-1:0]    n_rem;

    always_comb begin
        rem_sh = {r_rem, r_dvd[TIME_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        n_rem  = diff[TIME_W] ? rem_sh[TIME_W-1:0] : diff[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(TIME_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;

endmodule

`default_nettype wire

// ===== sv/multi_timer_expiry_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Table of TIMER_COUNT one-shot or periodic timers driven by request
// transactions. A start request arms a timer at now plus delay, a cancel
// request clears an active timer, and a process request scans the table in id
// order and returns one response per expired timer (the final one flagged
// last), or a single quiet response when nothing is due. The block takes one
// request at a time and is not ready while it works on one. Start, cancel and
// unknown requests, and a process request with nothing due, pass from the
// idle state, where they are accepted, to one execute step that loads the
// response register. A process request with expiries adds a pick step and
// an execute step for every expired timer; for an expired periodic timer
// the block then waits on a bit-serial remainder unit that retires one bit
// of the 32-bit elapsed time per cycle and then hands back the remainder.
// A stalled response holds the block in its execute step.
// There is no clearing pass after reset.
module multi_timer_expiry_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tmr_req_if.sink    i_req,
    tmr_rsp_if.source  o_rsp
);
    import tmr_pkg::*;

    `include "multi_timer_expiry_table_assert.svh"

    // Sequencer and latched request.
    t_state             r_state;
    t_state             n_state;
    t_req               r_req;
    t_tmr_mask          r_mask;
    t_tmr_mask          n_mask;
    t_tmr_idx           r_idx;
    t_tmr_idx           n_idx;

    // Timer table. The flags are reset; the rest is only read while the
    // matching active flag is set.
    t_tmr_mask          r_active;
    t_tmr_mask          r_periodic;
    logic [TIME_W-1:0]  r_deadline [TIMER_COUNT];
    logic [TIME_W-1:0]  r_period   [TIMER_COUNT];
    logic [PAY_W-1:0]   r_payload  [TIMER_COUNT];

    logic [CNT_W-1:0]   r_arm_cnt;
    logic [CNT_W-1:0]   n_arm_cnt;
    logic [CNT_W-1:0]   r_cancel_cnt;
    logic [CNT_W-1:0]   n_cancel_cnt;
    logic [CNT_W-1:0]   r_exp_cnt;
    logic [CNT_W-1:0]   n_exp_cnt;

    // Response register.
    logic               r_out_valid;
    logic               n_out_valid;
    t_rsp               r_out;
    t_rsp               n_out;

    // Table write strobes and helpers.
    logic               wr_arm;
    logic               wr_clr;
    logic               wr_deadline;
    logic               div_start;
    t_div_stat          div_stat;
    logic [TIME_W-1:0]  div_rem;
    logic [TIME_W-1:0]  elapsed;
    t_tmr_mask          due_mask;
    t_tmr_mask          rest_mask;
    t_tmr_idx           low_idx;
    logic               out_free;
    logic               out_load;
    logic               fire_load;
    logic               id_in_range;
    logic               start_ok;
    logic               cancel_ok;

    // Due timers are found once, against the incoming time, at acceptance.
    // The scan only moves deadlines of timers it has already visited, so the
    // mask stays valid for the rest of the process request and also tells
    // whether a given expiry is the last one.
    always_comb begin
        for (int i = 0; i < TIMER_COUNT; i++) begin
            due_mask[i] = r_active[i] && (i_req.payload.now_ms >= r_deadline[i]);
        end
    end

    always_comb begin
        low_idx = '0;
        for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                low_idx = TIMER_IDX_W'(i);
            end
        end
    end

    assign rest_mask   = r_mask & ~(t_tmr_mask'(1) << r_idx);
    assign id_in_range = (32'(r_req.slot_id) < 32'(TIMER_COUNT));
    assign start_ok    = id_in_range && (r_req.span_ms != '0);
    assign cancel_ok   = id_in_range && r_active[r_idx];
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign fire_load   = out_load && n_out.fired;

    // A firing timer satisfies now >= deadline, so the elapsed time never
    // borrows.
    assign elapsed     = r_req.now_ms - r_deadline[r_idx];

    // The remainder of the elapsed time over the period gives the catch-up:
    // deadline + (q + 1) * period equals now - remainder + period.
    tmr_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (elapsed),
        .i_divisor  (r_period[r_idx]),
        .o_stat     (div_stat),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        n_idx        = r_idx;
        n_arm_cnt    = r_arm_cnt;
        n_cancel_cnt = r_cancel_cnt;
        n_exp_cnt    = r_exp_cnt;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out        = r_out;
        out_load     = 1'b0;
        wr_arm       = 1'b0;
        wr_clr       = 1'b0;
        wr_deadline  = 1'b0;
        div_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_idx  = i_req.payload.slot_id[TIMER_IDX_W-1:0];
                    n_mask = due_mask;
                    if ((i_req.payload.mode == MODE_PROCESS) && (due_mask != '0)) begin
                        n_state = S_PICK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_PICK: begin
                n_idx   = low_idx;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    n_state     = S_IDLE;
                    unique case (r_req.mode)
                        MODE_START: begin
                            n_out.ok = start_ok;
                            if (start_ok) begin
                                wr_arm    = 1'b1;
                                n_arm_cnt = r_arm_cnt + 1'b1;
                            end
                        end
                        MODE_CANCEL: begin
                            n_out.ok = cancel_ok;
                            if (cancel_ok) begin
                                wr_clr       = 1'b1;
                                n_cancel_cnt = r_cancel_cnt + 1'b1;
                            end
                        end
                        MODE_PROCESS: begin
                            n_out.ok = 1'b1;
                            if (r_mask != '0) begin
                                n_exp_cnt           = r_exp_cnt + 1'b1;
                                n_out.fired         = 1'b1;
                                n_out.fired_id      = ID_W'(r_idx);
                                n_out.fired_payload = WORD_W'(r_payload[r_idx]);
                                n_out.stamp_ms      = r_req.now_ms;
                                n_out.last          = (rest_mask == '0);
                                n_mask              = rest_mask;
                                if (r_periodic[r_idx] && (r_period[r_idx] != '0)) begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end else begin
                                    // One-shot timers, and the unreachable
                                    // zero-period case, retire here.
                                    wr_clr  = 1'b1;
                                    n_state = (rest_mask != '0) ? S_PICK : S_IDLE;
                                end
                            end
                        end
                        default: begin
                            n_out.ok = 1'b0;
                        end
                    endcase
                    n_out.arm_total    = n_arm_cnt;
                    n_out.cancel_total = n_cancel_cnt;
                    n_out.expiry_total = n_exp_cnt;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    wr_deadline = 1'b1;
                    n_state     = (r_mask != '0) ? S_PICK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_active     <= '0;
            r_periodic   <= '0;
            r_arm_cnt    <= '0;
            r_cancel_cnt <= '0;
            r_exp_cnt    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_mask       <= n_mask;
            r_arm_cnt    <= n_arm_cnt;
            r_cancel_cnt <= n_cancel_cnt;
            r_exp_cnt    <= n_exp_cnt;
            r_out_valid  <= n_out_valid;
            if (wr_arm) begin
                r_active[r_idx]   <= 1'b1;
                r_periodic[r_idx] <= r_req.repeat_req;
            end else if (wr_clr) begin
                r_active[r_idx]   <= 1'b0;
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_out <= n_out;
        if ((r_state == S_IDLE) && i_req.valid) begin
            r_req <= i_req.payload;
        end
        if (wr_arm) begin
            r_deadline[r_idx] <= r_req.now_ms + r_req.span_ms;
            r_period[r_idx]   <= r_req.span_ms;
            r_payload[r_idx]  <= r_req.event_payload[PAY_W-1:0];
        end else if (wr_deadline) begin
            r_deadline[r_idx] <= r_req.now_ms - div_rem + r_period[r_idx];
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // The remainder unit must be running for the whole catch-up step.
    `TMR_ASSERT_IMP(a_div_running, i_clk, i_rst_n, r_state == S_DIV, div_stat.busy || div_stat.done)
    // The pending expiry set only shrinks when a response is loaded.
    `TMR_ASSERT_NXT(a_mask_hold_div, i_clk, i_rst_n, r_state == S_DIV, r_mask == $past(r_mask))
    // A timer is picked only when some expiry is still pending.
    `TMR_ASSERT_IMP(a_pick_pending, i_clk, i_rst_n, r_state == S_PICK, r_mask != '0)
    // Every reported expiry bumps the expiry count by exactly one.
    `TMR_ASSERT_NXT(a_fire_counts, i_clk, i_rst_n, fire_load, r_exp_cnt == $past(r_exp_cnt) + 32'd1)

endmodule

`default_nettype wire

// ===== tb/tb_multi_timer_expiry_table.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the timer table. Request transactions are driven on
// the falling edge and every accepted request is folded into a local copy of
// the table, which queues the responses it should produce. Responses are
// checked field by field, in order, on the rising edge. Both sides of the
// link idle at random, and one phase holds the response side off for a long
// stretch so that the block backs up into its request port.
module tb_multi_timer_expiry_table;
    import tmr_pkg::*;

    // The package names only the three defined operations; the fourth code
    // must come back with a single rejected response.
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;

    // Payload bits kept by the block when it stores an event word.
    localparam logic [WORD_W-1:0] PAY_MASK =
        (PAY_W >= WORD_W) ? '1 : WORD_W'((64'd1 << PAY_W) - 64'd1);

    // Cycles without any transaction before the run is declared hung. A
    // periodic expiry waits on the bit-serial remainder unit, up to eight may
    // come from one request, and the long response hold-off adds HOLD_OFF more.
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_OFF      = 200;

    logic i_clk;
    logic i_rst_n;

    tmr_req_if req_ch ();
    tmr_rsp_if rsp_ch ();

    multi_timer_expiry_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Local copy of the timer table and its running counts.
    logic              tbl_active   [TIMER_COUNT];
    logic              tbl_periodic [TIMER_COUNT];
    logic [TIME_W-1:0] tbl_deadline [TIMER_COUNT];
    logic [TIME_W-1:0] tbl_period   [TIMER_COUNT];
    logic [WORD_W-1:0] tbl_payload  [TIMER_COUNT];
    logic [CNT_W-1:0]  arms_seen;
    logic [CNT_W-1:0]  cancels_seen;
    logic [CNT_W-1:0]  expiries_seen;

    // Responses the table owes, oldest first.
    t_rsp timer_results_due [$];

    int error_count     = 0;
    int gap_max         = 12;
    int stall_max       = 12;
    int stall_left      = 0;
    int rsp_hold_cycles = 0;

    // Running notion of the current time used by the random traffic.
    logic [TIME_W-1:0] tick_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------

    function automatic t_rsp with_totals(input t_rsp x);
        x.arm_total    = arms_seen;
        x.cancel_total = cancels_seen;
        x.expiry_total = expiries_seen;
        return x;
    endfunction

    // Folds one accepted request into the table and queues its responses.
    function automatic void apply_timer_request(input t_req r);
        t_rsp       rsp;
        int         idx;
        int         last_hit;
        logic [63:0] behind;
        logic [63:0] steps;
        logic [63:0] moved;
        rsp = '0;
        idx = int'(r.slot_id);
        case (r.mode)
            MODE_START: begin
                if (idx < TIMER_COUNT && r.span_ms != '0) begin
                    // A start on a running timer simply re-arms it.
                    tbl_active[idx]   = 1'b1;
                    tbl_periodic[idx] = r.repeat_req;
                    tbl_deadline[idx] = r.now_ms + r.span_ms;
                    tbl_period[idx]   = r.span_ms;
                    tbl_payload[idx]  = r.event_payload & PAY_MASK;
                    arms_seen         = arms_seen + 1'b1;
                    rsp.ok            = 1'b1;
                end
                rsp.last = 1'b1;
                timer_results_due.push_back(with_totals(rsp));
            end
            MODE_CANCEL: begin
                if (idx < TIMER_COUNT && tbl_active[idx]) begin
                    tbl_active[idx] = 1'b0;
                    cancels_seen    = cancels_seen + 1'b1;
                    rsp.ok          = 1'b1;
                end
                rsp.last = 1'b1;
                timer_results_due.push_back(with_totals(rsp));
            end
            MODE_PROCESS: begin
                // Whether a timer fires depends only on its own entry, so the
                // last expiry of the scan can be found before any update.
                last_hit = -1;
                for (int i = 0; i < TIMER_COUNT; i++) begin
                    if (tbl_active[i] && r.now_ms >= tbl_deadline[i]) begin
                        last_hit = i;
                    end
                end
                if (last_hit < 0) begin
                    rsp.ok   = 1'b1;
                    rsp.last = 1'b1;
                    timer_results_due.push_back(with_totals(rsp));
                end else begin
                    for (int i = 0; i < TIMER_COUNT; i++) begin
                        if (tbl_active[i] && r.now_ms >= tbl_deadline[i]) begin
                            expiries_seen     = expiries_seen + 1'b1;
                            rsp               = '0;
                            rsp.ok            = 1'b1;
                            rsp.fired         = 1'b1;
                            rsp.fired_id      = ID_W'(i);
                            rsp.fired_payload = tbl_payload[i];
                            rsp.stamp_ms      = r.now_ms;
                            rsp.last          = (i == last_hit);
                            timer_results_due.push_back(with_totals(rsp));
                            if (tbl_periodic[i] && tbl_period[i] != '0) begin
                                // Skip whole periods until the deadline is
                                // past now; a step over the top of the 32-bit
                                // range wraps and ends the catch-up.
                                behind = {32'd0, r.now_ms} - {32'd0, tbl_deadline[i]};
                                steps  = behind / {32'd0, tbl_period[i]} + 64'd1;
                                moved  = {32'd0, tbl_deadline[i]}
                                         + steps * {32'd0, tbl_period[i]};
                                tbl_deadline[i] = moved[TIME_W-1:0];
                            end else begin
                                tbl_active[i] = 1'b0;
                            end
                        end
                    end
                end
            end
            default: begin
                rsp.last = 1'b1;
                timer_results_due.push_back(with_totals(rsp));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic t_req make_request(input logic [MODE_W-1:0] mode,
                                          input logic [ID_W-1:0]   id,
                                          input logic [TIME_W-1:0] now,
                                          input logic [TIME_W-1:0] delay,
                                          input logic              rep,
                                          input logic [WORD_W-1:0] pay);
        t_req r;
        r.mode          = mode;
        r.slot_id       = id;
        r.now_ms        = now;
        r.span_ms       = delay;
        r.repeat_req    = rep;
        r.event_payload = pay;
        return r;
    endfunction

    // Presents one request after a random gap and waits for its handshake.
    // Valid is left high, so the next call either replaces the payload on
    // the following falling edge or lowers valid for its own gap; the drain
    // task lowers it when the stream pauses.
    task automatic send_request(input t_req r);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.payload <= r;
        req_ch.valid   <= 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        apply_timer_request(r);
    endtask

    // Stops offering requests and waits until every owed response is in.
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (timer_results_due.size() != 0) @(posedge i_clk);
    endtask

    // Random traffic mostly follows a moving clock so that timers armed with
    // short delays actually expire, with occasional jumps, rejected starts
    // and stray ids mixed in.
    function automatic t_req make_random_request();
        t_req r;
        int   pick;
        r.mode          = MODE_PROCESS;
        r.slot_id       = ($urandom_range(0, 9) == 0)
                          ? ID_W'($urandom_range(0, (1 << ID_W) - 1))
                          : ID_W'($urandom_range(0, TIMER_COUNT - 1));
        r.now_ms        = $urandom;
        r.span_ms       = $urandom;
        r.repeat_req    = 1'($urandom_range(0, 1));
        r.event_payload = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.mode   = MODE_START;
            r.now_ms = tick_ms;
            case ($urandom_range(0, 19))
                0:       r.span_ms = '0;
                1:       r.span_ms = $urandom;
                default: r.span_ms = $urandom_range(1, 150);
            endcase
        end else if (pick < 60) begin
            r.mode = MODE_CANCEL;
        end else if (pick < 96) begin
            r.mode = MODE_PROCESS;
            if ($urandom_range(0, 24) != 0) begin
                tick_ms = tick_ms + $urandom_range(0, 80);
            end else begin
                tick_ms = $urandom;
            end
            r.now_ms = tick_ms;
        end else begin
            r.mode = MODE_UNKNOWN;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Ready waits a random number of cycles after each response. A requested
    // hold-off keeps it low for a long stretch counted here.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_cycles) @(negedge i_clk);
                rsp_hold_cycles = 0;
            end else if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        end
    endtask

    task automatic check_response(input t_rsp got);
        t_rsp want;
        if (timer_results_due.size() == 0) begin
            report_mismatch($sformatf("response with nothing owed: %h", got));
        end else begin
            want = timer_results_due.pop_front();
            compare_field("ok",            32'(got.ok),        32'(want.ok));
            compare_field("fired",         32'(got.fired),     32'(want.fired));
            compare_field("fired_id",      32'(got.fired_id),  32'(want.fired_id));
            compare_field("fired_payload", got.fired_payload,  want.fired_payload);
            compare_field("stamp_ms",      got.stamp_ms,       want.stamp_ms);
            compare_field("last",          32'(got.last),      32'(want.last));
            compare_field("arm_total",     got.arm_total,      want.arm_total);
            compare_field("cancel_total",  got.cancel_total,   want.cancel_total);
            compare_field("expiry_total",  got.expiry_total,   want.expiry_total);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready) begin
                check_response(rsp_ch.payload);
                stall_left = $urandom_range(0, stall_max);
            end
        end
    end

    // Declares the run hung and fails it when transactions stop moving.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("multi_timer_expiry_table regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Starts, re-arm, rejected starts, cancels and the unknown operation,
    // followed by a quiet scan, a single one-shot expiry and a scan at the
    // very top of the time range.
    task automatic test_arm_and_cancel();
        gap_max   = 12;
        stall_max = 12;
        send_request(make_request(MODE_START, 4'd0, 32'd0, 32'd1, 1'b0, 32'hFFFF_FFFF));
        // Deadline wraps past the top of the time range.
        send_request(make_request(MODE_START, 4'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, 32'd0));
        send_request(make_request(MODE_START, 4'd8, 32'd5, 32'd5, 1'b0, 32'h1234_5678));
        send_request(make_request(MODE_START, 4'd15, 32'd5, 32'd5, 1'b1, 32'h8765_4321));
        // Zero delay is refused and leaves timer 3 idle.
        send_request(make_request(MODE_START, 4'd3, 32'd5, 32'd0, 1'b1, 32'hDEAD_BEEF));
        send_request(make_request(MODE_START, 4'd0, 32'd0, 32'd10, 1'b0, 32'h5A5A_A5A5));
        send_request(make_request(MODE_CANCEL, 4'd7, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_CANCEL, 4'd7, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_CANCEL, 4'd15, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_UNKNOWN, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  1'b1, 32'hFFFF_FFFF));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd10, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0));
        wait_for_results();
    endtask

    // Fills the whole table so one scan fires every timer, then lets a
    // periodic timer's catch-up cross the top of the range, which makes it
    // fire again on the very next scan.
    task automatic test_expiry_paths();
        for (int i = 0; i < TIMER_COUNT; i++) begin
            send_request(make_request(MODE_START, ID_W'(i), 32'd100, TIME_W'(i + 1),
                                      1'(i % 2), WORD_W'(32'h1111_1111 * (i + 1))));
        end
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd1000, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_START, 4'd1, 32'hFFFF_FF00, 32'h80, 1'b1,
                                  32'hC0DE_0001));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'hFFFF_FFF0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd5, 32'd0, 1'b0, 32'd0));
        wait_for_results();
    endtask

    // The response side stops for a long stretch while requests keep coming
    // back to back, so the block must stall its request port.
    task automatic test_response_backpressure();
        gap_max         = 0;
        stall_max       = 3;
        rsp_hold_cycles = HOLD_OFF;
        for (int i = 0; i < 4; i++) begin
            send_request(make_request(MODE_START, ID_W'(i), 32'd20000, TIME_W'(5 * (i + 1)),
                                      1'(i % 2), $urandom));
        end
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd20030, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_CANCEL, 4'd1, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_CANCEL, 4'd2, 32'd0, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_START, 4'd9, 32'd20030, 32'd7, 1'b1, $urandom));
        send_request(make_request(MODE_PROCESS, 4'd0, 32'd20100, 32'd0, 1'b0, 32'd0));
        send_request(make_request(MODE_UNKNOWN, 4'd0, 32'd0, 32'd0, 1'b0, 32'd0));
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count, input int gmax, input int smax,
                                       input logic [TIME_W-1:0] base_ms);
        gap_max   = gmax;
        stall_max = smax;
        tick_ms   = base_ms;
        repeat (count) send_request(make_random_request());
        wait_for_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        for (int i = 0; i < TIMER_COUNT; i++) begin
            tbl_active[i]   = 1'b0;
            tbl_periodic[i] = 1'b0;
            tbl_deadline[i] = '0;
            tbl_period[i]   = '0;
            tbl_payload[i]  = '0;
        end
        arms_seen     = '0;
        cancels_seen  = '0;
        expiries_seen = '0;
        tick_ms       = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_arm_and_cancel();
        test_expiry_paths();
        test_response_backpressure();
        // Random phases: no idling at all, idling on both sides, a stream
        // that starts near the top of the time range, and a random starting time.
        test_random_traffic(60, 0, 0, 32'd0);
        test_random_traffic(60, 12, 12, 32'd5000);
        test_random_traffic(60, 12, 0, 32'hFFFF_F800);
        test_random_traffic(60, 0, 12, $urandom);

        // Any response arriving now is one that nothing asked for.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("multi_timer_expiry_table regression: pass");
        end else begin
            $display("multi_timer_expiry_table regression: fail");
        end
        $finish;
    end

endmodule
